// ----- hw/rtl/merge_sort_engine_defines.svh -----
// Assertion macros for the sort engine RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define MSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, evaluated during reset as well.
`define MSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSE_ASSERT(lbl, prop, msg)
`define MSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/mse_pkg.sv -----
// Shared types and constants for the sort engine.
// Used by mse_cell and merge_sort_engine; depends on nothing.
package mse_pkg;

  // Width of one stored integer.
  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Controller states.
  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  // Per-cycle commands broadcast to every cell of the row.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/mse_cell.sv -----
// One cell of the sorting row: holds one value of the ordered batch.
// Depends on mse_pkg for the data and command types.
module mse_cell (
  input  logic                clk,
  input  mse_pkg::cell_ctrl_t ctrl,
  input  mse_pkg::data_t      ins_value,
  input  logic                occupied,
  input  mse_pkg::data_t      left_value,
  input  logic                left_gt,
  input  mse_pkg::data_t      right_value,
  output mse_pkg::data_t      value,
  output logic                gt
);

  // The cell is occupied and its held value is larger than the value being inserted.
  assign gt = occupied && (value > ins_value);

  // Insert: make room by taking the left neighbor, or take the new item at
  // its place. Shift: move one place toward the head of the row.
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_gt) begin
        value <= left_value;
      end else if (gt || !occupied) begin
        value <= ins_value;
      end
    end else if (ctrl.shift) begin
      value <= right_value;
    end
  end

endmodule

// ----- hw/rtl/merge_sort_engine.sv -----
// Top level of the batch sorter: controller and a row of mse_cell cells.
// Depends on mse_pkg, mse_cell and merge_sort_engine_defines.svh.
//
// Usage: present sample_value and batch_end with start high; an item is
// taken at a rising edge where start is high and busy is low. Each item is
// inserted directly into a row of DEPTH cells that always keeps the
// stored values in ascending signed order, so items can be loaded back to
// back. An item that arrives while DEPTH values are already held is
// dropped, and every result of that batch carries batch_truncated.
// The item with batch_end set closes the batch: busy rises in the next
// cycle, the first result appears once the state register has entered
// emit and the result register has captured the head of the row, and then
// one result per cycle follows for the N stored values, taken from the
// head of the row while the row shifts by one cell per cycle.
// Each result is shown for one cycle with result_strobe high; the last one
// has final_result set. The receiver cannot stall. busy falls during the
// final result's cycle, so the next batch may start then.
// Reset empties the row and clears the overflow flag.
`include "merge_sort_engine_defines.svh"
module merge_sort_engine #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mse_pkg::data_t sample_value,
  input  logic           batch_end,
  output logic           result_strobe,
  output mse_pkg::data_t sorted_value,
  output logic           final_result,
  output logic           batch_truncated
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  mse_pkg::state_t     state;
  mse_pkg::state_t     state_next;
  logic [CNT_W-1:0]    count;
  logic                overflow;
  logic                accept;
  logic                full;
  mse_pkg::cell_ctrl_t ctrl;
  mse_pkg::data_t      cell_value [DEPTH];
  logic                cell_gt    [DEPTH];
  logic                cell_occ   [DEPTH];

  assign busy   = (state == mse_pkg::ST_EMIT);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));

  // Commands for the row.
  always_comb begin
    ctrl.insert = accept && !full;
    ctrl.shift  = (state == mse_pkg::ST_EMIT);
  end

  // Next state: emit after the closing item, return when the row is empty.
  always_comb begin
    state_next = state;
    case (state)
      mse_pkg::ST_LOAD: begin
        if (accept && batch_end) begin
          state_next = mse_pkg::ST_EMIT;
        end
      end
      mse_pkg::ST_EMIT: begin
        if (count <= CNT_W'(1)) begin
          state_next = mse_pkg::ST_LOAD;
        end
      end
      default: state_next = mse_pkg::ST_LOAD;
    endcase
  end

  // State, fill count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mse_pkg::ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.insert) begin
        count <= count + CNT_W'(1);
      end else if (accept && full) begin
        overflow <= 1'b1;
      end
      if (state == mse_pkg::ST_EMIT) begin
        if (count != '0) begin
          count <= count - CNT_W'(1);
        end
        if (count <= CNT_W'(1)) begin
          overflow <= 1'b0;
        end
      end
    end
  end

  // Result register: the head of the row is taken once per emit cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == mse_pkg::ST_EMIT) && (count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mse_pkg::ST_EMIT) begin
      sorted_value    <= cell_value[0];
      final_result    <= (count == CNT_W'(1));
      batch_truncated <= overflow;
    end
  end

  // The row of cells; each sees its neighbors' values and the left neighbor's compare result.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mse_pkg::data_t left_v;
    mse_pkg::data_t right_v;
    logic           left_g;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_v = cell_value[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_value[i+1];
    end

    mse_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .ins_value   (sample_value),
      .occupied    (cell_occ[i]),
      .left_value  (left_v),
      .left_gt     (left_g),
      .right_value (right_v),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  // Checks on the controller.
  `MSE_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "fill count beyond row depth")
  `MSE_ASSERT(a_strobe_src, result_strobe |-> $past(state == mse_pkg::ST_EMIT), "result without emit")
  `MSE_ASSERT(a_final_empty, (result_strobe && final_result) |-> (count == '0), "row not empty after last result")
  `MSE_ASSERT(a_emit_nonempty, $rose(busy) |-> (count != '0), "emit started on an empty row")
  `MSE_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !result_strobe), "not idle after reset")

endmodule
